[hw/rtl/bsr_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bsr_pkg
// shared types and constants of the byte stack with rotate
// ----------------------------------------------------------------------------
package bsr_pkg;

  localparam int unsigned MaxResults = 64;   // longest print burst
  localparam int unsigned CapW       = 7;
  localparam int unsigned ValW       = 8;
  localparam logic [CapW-1:0] CapReset = 7'd64;

  typedef enum logic [2:0] {
    OP_PUSH    = 3'd0,
    OP_POP     = 3'd1,
    OP_PEEK    = 3'd2,
    OP_DUP     = 3'd3,
    OP_ROT_UP  = 3'd4,
    OP_ROT_DN  = 3'd5,
    OP_PRINT   = 3'd6
  } op_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_EMPTY   = 2'd2,
    ST_REFUSED = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_ROT_UP,
    S_ROT_DN,
    S_ROT_FIN,
    S_PRINT
  } state_t;

  typedef struct packed {
    logic [ValW-1:0] value;
    logic            has_value;
    status_t         status;
    logic            last;
  } res_t;

endpackage
`default_nettype wire

[hw/rtl/bsr_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bsr_in_if / bsr_out_if
// valid/ready channels for command items and result items
// ----------------------------------------------------------------------------
interface bsr_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] operation;
  logic [7:0] push_value;
  logic [6:0] rotate_count;

  modport source (output valid, output operation, output push_value,
                  output rotate_count, input ready);
  modport sink   (input valid, input operation, input push_value,
                  input rotate_count, output ready);
endinterface

interface bsr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_value;
  logic       has_value;
  logic [1:0] status;
  logic       last;

  modport source (output valid, output out_value, output has_value,
                  output status, output last, input ready);
  modport sink   (input valid, input out_value, input has_value,
                  input status, input last, output ready);
endinterface
`default_nettype wire

[hw/rtl/byte_stack_with_rotate.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// byte_stack_with_rotate
// byte stack with push, pop, peek, dup, rotate up/down and print
// ----------------------------------------------------------------------------
// usage
//   in_ch  : command items (operation, push_value, rotate_count), valid/ready
//   out_ch : result items (out_value, has_value, status, last), valid/ready
//   cfg_we / cfg_wdata : write of the capacity register, only while idle
// timing
//   one command at a time; a single-step result passes S_EXEC and the output register before out_ch
//   push, pop, peek, dup and refused or trivial rotates: S_IDLE, then S_EXEC
//   rotate of depth r: S_EXEC, S_ROT_UP or S_ROT_DN, S_ROT_FIN; one store read and write per element
//   print of n elements: one element per cycle from the store while the receiver takes them
//   the single read port of the store sets this order of steps
// reset
//   stack empty, capacity 64; store contents are undefined and never used
//   before written, so there is no clearing pass
// stalls
//   results sit in an output register; a stalled receiver holds the
//   sequencer, and a new item is taken once its last result is registered
// ----------------------------------------------------------------------------
module byte_stack_with_rotate #(
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     cfg_we,
  input  wire logic [bsr_pkg::CapW-1:0] cfg_wdata,
  bsr_in_if.sink                        in_ch,
  bsr_out_if.source                     out_ch
);
  import bsr_pkg::*;

  // only the first min(DEPTH, MaxResults) entries can ever be filled
  localparam int unsigned StoreDepth = (DEPTH < MaxResults) ? DEPTH : MaxResults;
  localparam int unsigned AddrW      = $clog2(StoreDepth);
  localparam int unsigned CntW       = $clog2(StoreDepth + 1);

  logic [CapW-1:0]  capacity_r, capacity_nxt;
  logic [CntW-1:0]  limit;

  logic             emit_valid, emit_ready;
  res_t             emit_res;
  logic             out_valid_r, out_valid_nxt;
  res_t             res_r, res_nxt;

  logic             mem_we, mem_re;
  logic [AddrW-1:0] mem_waddr, mem_raddr;
  logic [ValW-1:0]  mem_wdata, mem_rdata;

  // capacity register
  assign capacity_nxt = cfg_we ? cfg_wdata : capacity_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r <= CapReset;
    end else begin
      capacity_r <= capacity_nxt;
    end
  end

  // usable limit: capacity saturated at the store depth
  assign limit = (capacity_r > CapW'(StoreDepth)) ? CntW'(StoreDepth)
                                                  : CntW'(capacity_r);

  bsr_mem #(
    .Entries (StoreDepth),
    .AddrW   (AddrW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  bsr_ctrl #(
    .StoreDepth (StoreDepth),
    .AddrW      (AddrW),
    .CntW       (CntW)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .limit      (limit),
    .in_ch      (in_ch),
    .emit_valid (emit_valid),
    .emit_ready (emit_ready),
    .emit_res   (emit_res),
    .mem_we     (mem_we),
    .mem_waddr  (mem_waddr),
    .mem_wdata  (mem_wdata),
    .mem_re     (mem_re),
    .mem_raddr  (mem_raddr),
    .mem_rdata  (mem_rdata)
  );

  // output register: refilled in the cycle the receiver takes the item
  assign emit_ready    = !out_valid_r || out_ch.ready;
  assign out_valid_nxt = (emit_valid && emit_ready) || (out_valid_r && !out_ch.ready);
  assign res_nxt       = (emit_valid && emit_ready) ? emit_res : res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.out_value = res_r.value;
  assign out_ch.has_value = res_r.has_value;
  assign out_ch.status    = res_r.status;
  assign out_ch.last      = res_r.last;

`ifndef SYNTH
  a_limit_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (limit <= CntW'(StoreDepth)) && (CapW'(limit) <= capacity_r))
    else $error("limit out of range");

  a_no_result_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ch.ready) |-> !emit_ready)
    else $error("pending result could be overwritten");

  a_no_accept_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("second item taken before the first finished");
`endif

endmodule
`default_nettype wire

[hw/rtl/bsr_mem.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bsr_mem
// stack storage, one write port and one read port with registered data
// ----------------------------------------------------------------------------
module bsr_mem #(
  parameter int unsigned Entries = 64,
  parameter int unsigned AddrW   = 6
) (
  input  wire logic                    clk,
  input  wire logic                    we,
  input  wire logic [AddrW-1:0]        waddr,
  input  wire logic [bsr_pkg::ValW-1:0] wdata,
  input  wire logic                    re,
  input  wire logic [AddrW-1:0]        raddr,
  output      logic [bsr_pkg::ValW-1:0] rdata
);
  import bsr_pkg::*;

  logic [ValW-1:0] mem [Entries];
  logic [ValW-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

[hw/rtl/bsr_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bsr_ctrl
// command sequencer: reads the store, moves elements and issues results
// ----------------------------------------------------------------------------
module bsr_ctrl #(
  parameter int unsigned StoreDepth = 64,
  parameter int unsigned AddrW      = 6,
  parameter int unsigned CntW       = 7
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic [CntW-1:0]          limit,
  bsr_in_if.sink                        in_ch,
  output      logic                     emit_valid,
  input  wire logic                     emit_ready,
  output      bsr_pkg::res_t            emit_res,
  output      logic                     mem_we,
  output      logic [AddrW-1:0]         mem_waddr,
  output      logic [bsr_pkg::ValW-1:0] mem_wdata,
  output      logic                     mem_re,
  output      logic [AddrW-1:0]         mem_raddr,
  input  wire logic [bsr_pkg::ValW-1:0] mem_rdata
);
  import bsr_pkg::*;

  state_t            state_r, state_nxt;
  logic [CntW-1:0]   count_r, count_nxt;
  op_t               op_r, op_nxt;
  logic [ValW-1:0]   pv_r, pv_nxt;
  logic [CapW-1:0]   rc_r, rc_nxt;
  logic [AddrW-1:0]  idx_r, idx_nxt;
  logic [ValW-1:0]   tmp_r, tmp_nxt;

  logic [CapW-1:0]   count_ext;
  logic [AddrW-1:0]  base;
  logic [AddrW-1:0]  top_addr;
  logic              full, empty, r_bad, r_small, emit_hs;

  assign count_ext = CapW'(count_r);
  assign base      = AddrW'(count_ext - rc_r);
  assign top_addr  = AddrW'(count_r - CntW'(1));
  assign full      = (count_r >= limit);
  assign empty     = (count_r == '0);
  assign r_bad     = (rc_r > count_ext);
  assign r_small   = (rc_r < CapW'(2));
  assign emit_hs   = emit_valid && emit_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r  <= op_nxt;
    pv_r  <= pv_nxt;
    rc_r  <= rc_nxt;
    idx_r <= idx_nxt;
    tmp_r <= tmp_nxt;
  end

  always_comb begin
    state_nxt   = state_r;
    count_nxt   = count_r;
    op_nxt      = op_r;
    pv_nxt      = pv_r;
    rc_nxt      = rc_r;
    idx_nxt     = idx_r;
    tmp_nxt     = tmp_r;
    in_ch.ready = 1'b0;
    emit_valid  = 1'b0;
    emit_res    = '{value: '0, has_value: 1'b0, status: ST_OK, last: 1'b1};
    mem_we      = 1'b0;
    mem_waddr   = count_r[AddrW-1:0];
    mem_wdata   = pv_r;
    mem_re      = 1'b0;
    mem_raddr   = top_addr;

    case (state_r)
      S_IDLE: begin
        in_ch.ready = 1'b1;
        // fetch the element the command needs first: top, or depth r
        mem_re = in_ch.valid;
        if (op_t'(in_ch.operation) == OP_ROT_DN) begin
          mem_raddr = AddrW'(count_ext - in_ch.rotate_count);
        end
        if (in_ch.valid) begin
          op_nxt    = op_t'(in_ch.operation);
          pv_nxt    = in_ch.push_value;
          rc_nxt    = in_ch.rotate_count;
          state_nxt = S_EXEC;
        end
      end

      S_EXEC: begin
        emit_valid = 1'b1;
        case (op_r)
          OP_PUSH: begin
            if (full) begin
              emit_res.status = ST_FULL;
            end else begin
              mem_we = 1'b1;
              if (emit_hs) count_nxt = count_r + CntW'(1);
            end
          end
          OP_POP, OP_PEEK: begin
            if (empty) begin
              emit_res.status = ST_EMPTY;
            end else begin
              emit_res.value     = mem_rdata;
              emit_res.has_value = 1'b1;
              if (emit_hs && op_r == OP_POP) count_nxt = count_r - CntW'(1);
            end
          end
          OP_DUP: begin
            if (empty) begin
              emit_res.status = ST_EMPTY;
            end else if (full) begin
              emit_res.status = ST_FULL;
            end else begin
              mem_we    = 1'b1;
              mem_wdata = mem_rdata;
              if (emit_hs) count_nxt = count_r + CntW'(1);
            end
          end
          OP_ROT_UP, OP_ROT_DN: begin
            if (r_bad) begin
              emit_res.status = ST_REFUSED;
            end else if (!r_small) begin
              emit_valid = 1'b0;
              tmp_nxt    = mem_rdata;
              mem_re     = 1'b1;
              if (op_r == OP_ROT_UP) begin
                mem_raddr = AddrW'(count_r - CntW'(2));
                state_nxt = S_ROT_UP;
              end else begin
                mem_raddr = base + AddrW'(1);
                state_nxt = S_ROT_DN;
              end
              idx_nxt = mem_raddr;
            end
          end
          OP_PRINT: begin
            if (empty) begin
              emit_res.status = ST_EMPTY;
            end else begin
              emit_valid = 1'b0;
              idx_nxt    = top_addr;
              state_nxt  = S_PRINT;
            end
          end
          default: ;
        endcase
        if (emit_hs) state_nxt = S_IDLE;
      end

      S_ROT_UP: begin
        // shift one element up while the next lower one is read
        mem_we    = 1'b1;
        mem_waddr = idx_r + AddrW'(1);
        mem_wdata = mem_rdata;
        if (idx_r == base) begin
          state_nxt = S_ROT_FIN;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = idx_r - AddrW'(1);
          idx_nxt   = mem_raddr;
        end
      end

      S_ROT_DN: begin
        mem_we    = 1'b1;
        mem_waddr = idx_r - AddrW'(1);
        mem_wdata = mem_rdata;
        if (idx_r == top_addr) begin
          state_nxt = S_ROT_FIN;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = idx_r + AddrW'(1);
          idx_nxt   = mem_raddr;
        end
      end

      S_ROT_FIN: begin
        // drop the saved element into its slot, rewritten while stalled
        mem_we     = 1'b1;
        mem_waddr  = idx_r;
        mem_wdata  = tmp_r;
        emit_valid = 1'b1;
        if (emit_hs) state_nxt = S_IDLE;
      end

      S_PRINT: begin
        emit_valid         = 1'b1;
        emit_res.value     = mem_rdata;
        emit_res.has_value = 1'b1;
        emit_res.last      = (idx_r == '0);
        if (emit_hs) begin
          if (idx_r == '0) begin
            state_nxt = S_IDLE;
          end else begin
            mem_re    = 1'b1;
            mem_raddr = idx_r - AddrW'(1);
            idx_nxt   = mem_raddr;
          end
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

`ifndef SYNTH
  a_no_rw_same_entry: assert property (@(posedge clk) disable iff (!rst_n)
    (mem_we && mem_re) |-> (mem_waddr != mem_raddr))
    else $error("store read and write hit the same entry");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CntW'(StoreDepth))
    else $error("element count above store depth");

  a_no_emit_while_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready |-> !emit_valid)
    else $error("result issued while taking a new item");

  a_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (emit_valid && !emit_res.has_value) |-> (emit_res.value == '0))
    else $error("value set on a result without element");

  a_count_only_in_exec: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_EXEC) |=> $stable(count_r))
    else $error("element count moved outside command execution");
`endif

endmodule
`default_nettype wire

[tb/tb_top.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the byte stack with rotate
// ----------------------------------------------------------------------------
// a mirror of the stack lives in the bench; every command item taken by the
// block is applied to the mirror, which queues the result items the block
// must produce. a monitor pops that queue for each result item and compares
// all fields. directed tests cover empty and full corners, the rotations and
// capacity extremes; random tests run mostly legal traffic with some noise,
// while both channels idle at random
// ----------------------------------------------------------------------------
module tb_top;
  import bsr_pkg::*;

  // operation code with no meaning, the block must answer it with ok
  localparam logic [2:0] OpReserved = 3'd7;
  localparam int unsigned StackMax = 64;

  logic                clk;
  logic                rst_n;
  logic                cfg_we;
  logic [CapW-1:0]     cfg_wdata;

  bsr_in_if  in_ch ();
  bsr_out_if out_ch ();

  byte_stack_with_rotate #(
    .DEPTH (StackMax)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  // mirror of the stack: bottom entry at index 0
  logic [7:0]      stack_mem [0:StackMax-1];
  int              stack_depth;
  logic [CapW-1:0] cap_reg;

  // result items still owed by the block, oldest first
  res_t            expected_results [$];

  int              err_count;
  bit              in_held;   // valid left high after the last accepted item
  bit              calm;      // no idling on either channel while set

  // clock, period 2
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // hard stop in case the block hangs
  initial begin
    #2000000;
    $display("tb: failure");
    $finish;
  end

  // idle length: mostly none or short, now and then long
  function automatic int pick_gap();
    int roll;
    if (calm) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 50) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 8);
    return $urandom_range(10, 30);
  endfunction

  function automatic void want_result(input logic [7:0] v, input logic h,
                                      input status_t s, input logic l);
    expected_results.push_back(res_t'{value: v, has_value: h, status: s, last: l});
  endfunction

  // apply one accepted command item to the mirror and queue its results
  function automatic void stack_apply(input logic [2:0] op, input logic [7:0] pv,
                                      input logic [6:0] rc);
    int         lim;
    int         n;
    int         base;
    logic [7:0] moved;
    lim = (cap_reg > 7'd64) ? 64 : int'(cap_reg);
    n   = stack_depth;
    case (op)
      OP_PUSH: begin
        if (n >= lim) begin
          want_result(8'h00, 1'b0, ST_FULL, 1'b1);
        end else begin
          stack_mem[n] = pv;
          stack_depth  = n + 1;
          want_result(8'h00, 1'b0, ST_OK, 1'b1);
        end
      end
      OP_POP: begin
        if (n == 0) begin
          want_result(8'h00, 1'b0, ST_EMPTY, 1'b1);
        end else begin
          stack_depth = n - 1;
          want_result(stack_mem[n-1], 1'b1, ST_OK, 1'b1);
        end
      end
      OP_PEEK: begin
        if (n == 0) want_result(8'h00, 1'b0, ST_EMPTY, 1'b1);
        else        want_result(stack_mem[n-1], 1'b1, ST_OK, 1'b1);
      end
      OP_DUP: begin
        // empty wins over full
        if (n == 0) begin
          want_result(8'h00, 1'b0, ST_EMPTY, 1'b1);
        end else if (n >= lim) begin
          want_result(8'h00, 1'b0, ST_FULL, 1'b1);
        end else begin
          stack_mem[n] = stack_mem[n-1];
          stack_depth  = n + 1;
          want_result(8'h00, 1'b0, ST_OK, 1'b1);
        end
      end
      OP_ROT_UP, OP_ROT_DN: begin
        if (int'(rc) > n) begin
          want_result(8'h00, 1'b0, ST_REFUSED, 1'b1);
        end else begin
          // depth 0 or 1 leaves the stack as it is
          if (rc >= 7'd2) begin
            base = n - int'(rc);
            if (op == OP_ROT_UP) begin
              moved = stack_mem[n-1];
              for (int i = n - 1; i > base; i--) stack_mem[i] = stack_mem[i-1];
              stack_mem[base] = moved;
            end else begin
              moved = stack_mem[base];
              for (int i = base; i + 1 < n; i++) stack_mem[i] = stack_mem[i+1];
              stack_mem[n-1] = moved;
            end
          end
          want_result(8'h00, 1'b0, ST_OK, 1'b1);
        end
      end
      OP_PRINT: begin
        if (n == 0) begin
          want_result(8'h00, 1'b0, ST_EMPTY, 1'b1);
        end else begin
          for (int i = 0; i < n; i++)
            want_result(stack_mem[n-1-i], 1'b1, ST_OK, (i == n - 1));
        end
      end
      default: want_result(8'h00, 1'b0, ST_OK, 1'b1);
    endcase
  endfunction

  // drop valid if it was left high after the last item
  task automatic release_input();
    if (in_held) in_ch.valid <= 1'b0;
    in_held = 1'b0;
  endtask

  // send one command item; valid stays high when the next one follows at once
  task automatic send_cmd(input logic [2:0] op, input logic [7:0] pv,
                          input logic [6:0] rc);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      release_input();
      repeat (gap) @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.operation    <= op;
    in_ch.push_value   <= pv;
    in_ch.rotate_count <= rc;
    do @(posedge clk); while (!in_ch.ready);
    in_held = 1'b1;
    stack_apply(op, pv, rc);
  endtask

  // hold the input until every owed result has come, then let the block settle
  task automatic drain_results();
    release_input();
    while (expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // capacity write, only with the block idle
  task automatic write_capacity(input logic [CapW-1:0] v);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cap_reg = v;
    cfg_we  <= 1'b0;
  endtask

  task automatic empty_stack();
    while (stack_depth > 0) send_cmd(OP_POP, 8'($urandom), 7'($urandom));
  endtask

  // mostly legal traffic for the current depth, with a little noise
  task automatic random_cmd();
    int         roll;
    logic [2:0] op;
    logic [7:0] pv;
    logic [6:0] rc;
    roll = $urandom_range(0, 99);
    pv   = 8'($urandom);
    rc   = 7'($urandom_range(0, stack_depth));
    if (roll < 32)      op = OP_PUSH;
    else if (roll < 48) op = OP_POP;
    else if (roll < 56) op = OP_PEEK;
    else if (roll < 64) op = OP_DUP;
    else if (roll < 75) op = OP_ROT_UP;
    else if (roll < 86) op = OP_ROT_DN;
    else if (roll < 94) op = OP_PRINT;
    else if (roll < 96) op = OpReserved;
    else begin
      // rotate with any count, usually refused
      op = $urandom_range(0, 1) ? OP_ROT_UP : OP_ROT_DN;
      rc = 7'($urandom);
    end
    send_cmd(op, pv, rc);
  endtask

  // every operation but push on an empty stack
  task automatic test_empty_stack();
    send_cmd(OP_POP,     8'h00, 7'd0);
    send_cmd(OP_PEEK,    8'h00, 7'd0);
    send_cmd(OP_DUP,     8'h00, 7'd0);
    send_cmd(OP_PRINT,   8'h00, 7'd0);
    send_cmd(OP_ROT_UP,  8'h00, 7'd1);   // refused, count above depth
    send_cmd(OP_ROT_DN,  8'h00, 7'd0);   // zero count is fine
    send_cmd(OpReserved, 8'hff, 7'h7f);
  endtask

  // push, peek, dup, print and the rotations on a short stack
  task automatic test_basic_ops();
    send_cmd(OP_PUSH,   8'h00, 7'd0);
    send_cmd(OP_PUSH,   8'hff, 7'h7f);
    send_cmd(OP_PUSH,   8'ha5, 7'd0);
    send_cmd(OP_PEEK,   8'h00, 7'd0);
    send_cmd(OP_DUP,    8'h00, 7'd0);
    send_cmd(OP_ROT_UP, 8'h00, 7'd3);
    send_cmd(OP_ROT_DN, 8'h00, 7'd3);
    send_cmd(OP_ROT_DN, 8'h00, 7'd4);   // whole stack
    send_cmd(OP_PRINT,  8'h00, 7'd0);
    send_cmd(OP_ROT_UP, 8'h00, 7'd5);   // one past the depth
    send_cmd(OP_ROT_DN, 8'h00, 7'h7f);
    send_cmd(OP_ROT_UP, 8'h00, 7'd1);   // no change
    send_cmd(OP_POP,    8'h00, 7'd0);
  endtask

  // capacity zero, one and lowered below the current depth
  task automatic test_capacity_edges();
    write_capacity(7'd0);
    send_cmd(OP_PUSH, 8'h3c, 7'd0);
    send_cmd(OP_DUP,  8'h00, 7'd0);
    send_cmd(OP_POP,  8'h00, 7'd0);     // pop still works over the limit
    write_capacity(7'd1);
    send_cmd(OP_PUSH, 8'h5a, 7'd0);
    empty_stack();
    send_cmd(OP_PUSH, 8'h81, 7'd0);
    send_cmd(OP_PUSH, 8'h18, 7'd0);     // full at one
  endtask

  // fill to the store size with the register above it, long prints and rotates
  task automatic test_fill_and_rotate();
    write_capacity(7'd127);
    while (stack_depth < int'(StackMax)) send_cmd(OP_PUSH, 8'($urandom), 7'($urandom));
    send_cmd(OP_PUSH,   8'h77, 7'd0);
    send_cmd(OP_DUP,    8'h00, 7'd0);
    send_cmd(OP_PRINT,  8'h00, 7'd0);
    send_cmd(OP_ROT_UP, 8'h00, 7'd64);
    send_cmd(OP_ROT_DN, 8'h00, 7'd64);
    send_cmd(OP_ROT_UP, 8'h00, 7'd65);
    send_cmd(OP_ROT_DN, 8'h00, 7'($urandom_range(2, 63)));
    send_cmd(OP_PRINT,  8'h00, 7'd0);
    write_capacity(7'd3);
    send_cmd(OP_PUSH,   8'h11, 7'd0);
    send_cmd(OP_DUP,    8'h00, 7'd0);
    repeat (4) send_cmd(OP_POP, 8'($urandom), 7'($urandom));
    repeat (2) random_cmd();
  endtask

  // short stacks hit full and empty often
  task automatic test_random_small_capacity();
    empty_stack();
    write_capacity(7'($urandom_range(1, 6)));
    repeat (10) random_cmd();
    write_capacity(7'd2);
    repeat (8) random_cmd();
  endtask

  // default capacity, a calm stretch, and a pause until all results are in
  task automatic test_random_mixed();
    write_capacity(CapReset);
    calm = 1'b1;
    repeat (5) random_cmd();
    calm = 1'b0;
    repeat (6) random_cmd();
    drain_results();
    repeat (6) random_cmd();
  endtask

  // result monitor and receiver-side idling
  initial begin : result_monitor
    int   stall_left;
    res_t want;
    stall_left   = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        if (expected_results.size() == 0) begin
          err_count++;
          if (err_count <= 10)
            $display("tb: unexpected result value %h has_value %b status %0d last %b",
                     out_ch.out_value, out_ch.has_value, out_ch.status, out_ch.last);
        end else begin
          want = expected_results.pop_front();
          if (out_ch.out_value !== want.value || out_ch.has_value !== want.has_value ||
              out_ch.status !== want.status || out_ch.last !== want.last) begin
            err_count++;
            if (err_count <= 10)
              $display("tb: mismatch exp %h/%b/%0d/%b got %h/%b/%0d/%b",
                       want.value, want.has_value, want.status, want.last,
                       out_ch.out_value, out_ch.has_value, out_ch.status, out_ch.last);
          end
        end
      end
      // ready low for a random stretch now and then
      if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        out_ch.ready <= 1'b1;
        if ($urandom_range(0, 3) == 0) stall_left = pick_gap();
      end
    end
  end

  initial begin
    rst_n              = 1'b0;
    cfg_we             = 1'b0;
    cfg_wdata          = '0;
    in_ch.valid        = 1'b0;
    in_ch.operation    = '0;
    in_ch.push_value   = '0;
    in_ch.rotate_count = '0;
    in_held            = 1'b0;
    calm               = 1'b0;
    err_count          = 0;
    stack_depth        = 0;
    cap_reg            = CapReset;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_stack();
    test_basic_ops();
    test_capacity_edges();
    test_random_small_capacity();
    test_random_mixed();
    test_fill_and_rotate();

    // everything owed must arrive, then a quiet tail for strays
    drain_results();
    repeat (16) @(posedge clk);
    if (err_count == 0 && expected_results.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
`default_nettype wire
